### design/btw_pkg.sv
// Shared types, constants and tag helpers for the BER TLV stream walker.
// Used by the parser, the result queue and the top level; depends on nothing.
package btw_pkg;

    // Width of the message byte counter and the number of long-form length bytes.
    localparam int OFFSET_BITS      = 16;
    localparam int MAX_LENGTH_BYTES = 2;
    localparam int POS_W            = OFFSET_BITS;
    localparam int NEXT_W           = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 2;
    localparam int LBL_W            = 2;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MASK = '1;

    // Result queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Parser phases.
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TAG       = 3'd1;
    localparam logic [2:0] PH_LEN_FIRST = 3'd2;
    localparam logic [2:0] PH_LEN_MORE  = 3'd3;
    localparam logic [2:0] PH_INT       = 3'd4;
    localparam logic [2:0] PH_SKIP      = 3'd5;
    localparam logic [2:0] PH_ERROR     = 3'd6;

    // Record status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE = 2'd2;
    localparam logic [1:0] ST_BAD_FORM = 2'd3;

    // Record kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_VALUE  = 1'b1;

    // Length octet fields.
    localparam logic [7:0] LONG_FORM_BIT  = 8'h80;
    localparam logic [7:0] LEN_COUNT_MASK = 8'h7F;

    // Known tags.
    localparam logic [7:0] T_INTEGER  = 8'h02;
    localparam logic [7:0] T_OCTETS   = 8'h04;
    localparam logic [7:0] T_NULL     = 8'h05;
    localparam logic [7:0] T_OID      = 8'h06;
    localparam logic [7:0] T_SEQUENCE = 8'h30;
    localparam logic [7:0] T_IPADDR   = 8'h40;
    localparam logic [7:0] T_COUNTER  = 8'h41;
    localparam logic [7:0] T_GAUGE    = 8'h42;
    localparam logic [7:0] T_TICKS    = 8'h43;
    localparam logic [7:0] T_OPAQUE   = 8'h44;
    localparam logic [7:0] T_PDU_LO   = 8'hA0;
    localparam logic [7:0] T_PDU_HI   = 8'hA4;

    localparam logic [2:0] INT_LEN_CAP   = 3'd4;
    localparam logic [2:0] INT_LEN_RESET = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tag;
        logic [15:0] vlen;
        logic [15:0] hoff;
        logic [15:0] voff;
        logic [15:0] noff;
        logic [1:0]  status;
        logic [31:0] ival;
        logic        last;
    } t_rec;

    function automatic logic is_constructed(input logic [7:0] t);
        return (t == T_SEQUENCE) || ((t >= T_PDU_LO) && (t <= T_PDU_HI));
    endfunction

    function automatic logic is_int_class(input logic [7:0] t);
        return (t == T_INTEGER) || (t == T_COUNTER) || (t == T_GAUGE) || (t == T_TICKS);
    endfunction

    function automatic logic is_known(input logic [7:0] t);
        return is_constructed(t) || is_int_class(t) || (t == T_OCTETS) ||
               (t == T_NULL) || (t == T_OID) || (t == T_IPADDR) || (t == T_OPAQUE);
    endfunction

endpackage

### design/btw_parser.sv
// Per-byte TLV parser state and the record logic for one message byte.
// Depends on btw_pkg for phases, tags and the record type.
module btw_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [7:0]    i_byte,
    input  logic          i_first,
    input  logic [2:0]    i_int_max_len,
    output btw_pkg::t_rec o_rec0,
    output btw_pkg::t_rec o_rec1,
    output logic [1:0]    o_num
);

    logic [2:0]                      r_phase, n_phase;
    logic [btw_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [btw_pkg::POS_W-1:0]       r_hoff, n_hoff;
    logic [7:0]                      r_tag, n_tag;
    logic [15:0]                     r_lacc, n_lacc;
    logic [btw_pkg::LBL_W-1:0]       r_lbl, n_lbl;
    logic [15:0]                     r_vbl, n_vbl;
    logic [31:0]                     r_vacc, n_vacc;

    logic [2:0]                      phase_eff;
    logic [btw_pkg::POS_W-1:0]       pos_eff;
    logic [15:0]                     lacc_eff;
    logic [btw_pkg::LBL_W-1:0]       lbl_eff;
    logic [15:0]                     vbl_eff;
    logic [31:0]                     vacc_eff;
    logic                            active;
    logic [btw_pkg::POS_W:0]         pos_p1;
    logic                            fin_do;
    logic [15:0]                     fin_len;
    logic [btw_pkg::NEXT_W-1:0]      next_off;
    logic [2:0]                      lim;
    logic                            len_bad;
    logic                            ovf;
    logic [31:0]                     acc_base;
    logic [6:0]                      cnt;
    logic [btw_pkg::POS_W-1:0]       int_voff;
    btw_pkg::t_rec                   rec0, rec1;
    logic [1:0]                      num;

    always_comb begin
        // A message start restarts the parser before the byte is looked at.
        phase_eff = r_phase;
        pos_eff   = r_pos;
        lacc_eff  = r_lacc;
        lbl_eff   = r_lbl;
        vbl_eff   = r_vbl;
        vacc_eff  = r_vacc;
        if (i_first) begin
            phase_eff = btw_pkg::PH_TAG;
            pos_eff   = '0;
            lacc_eff  = '0;
            lbl_eff   = '0;
            vbl_eff   = '0;
            vacc_eff  = '0;
        end

        n_phase = phase_eff;
        n_pos   = pos_eff;
        n_hoff  = r_hoff;
        n_tag   = r_tag;
        n_lacc  = lacc_eff;
        n_lbl   = lbl_eff;
        n_vbl   = vbl_eff;
        n_vacc  = vacc_eff;

        active   = (phase_eff != btw_pkg::PH_IDLE) && (phase_eff < btw_pkg::PH_ERROR);
        pos_p1   = {1'b0, pos_eff} + {{btw_pkg::POS_W{1'b0}}, 1'b1};
        fin_do   = 1'b0;
        fin_len  = '0;
        cnt      = i_byte[6:0] & btw_pkg::LEN_COUNT_MASK[6:0];
        acc_base = vacc_eff;
        int_voff = btw_pkg::POS_W'(pos_p1) - btw_pkg::POS_W'(lacc_eff);
        rec0     = '0;
        rec1     = '0;
        num      = 2'd0;

        if (active) begin
            case (phase_eff)
                btw_pkg::PH_TAG: begin
                    n_hoff = pos_eff;
                    n_tag  = i_byte;
                    n_lacc = '0;
                    if (!btw_pkg::is_known(i_byte)) begin
                        rec0.status = btw_pkg::ST_BAD_TYPE;
                        n_phase     = btw_pkg::PH_ERROR;
                        num         = 2'd1;
                    end else begin
                        n_phase = btw_pkg::PH_LEN_FIRST;
                    end
                end
                btw_pkg::PH_LEN_FIRST: begin
                    if ((i_byte & btw_pkg::LONG_FORM_BIT) == 8'd0) begin
                        n_lacc  = {8'd0, i_byte};
                        fin_len = {8'd0, i_byte};
                        fin_do  = 1'b1;
                    end else if ((cnt == 7'd0) || (cnt > 7'(btw_pkg::MAX_LENGTH_BYTES))) begin
                        rec0.status = btw_pkg::ST_BAD_FORM;
                        n_phase     = btw_pkg::PH_ERROR;
                        num         = 2'd1;
                    end else begin
                        n_lacc  = '0;
                        n_lbl   = cnt[btw_pkg::LBL_W-1:0];
                        n_phase = btw_pkg::PH_LEN_MORE;
                    end
                end
                btw_pkg::PH_LEN_MORE: begin
                    if (lacc_eff[15:8] != 8'd0) begin
                        rec0.status = btw_pkg::ST_BAD_FORM;
                        n_phase     = btw_pkg::PH_ERROR;
                        num         = 2'd1;
                    end else begin
                        n_lacc = {lacc_eff[7:0], i_byte};
                        n_lbl  = lbl_eff - btw_pkg::LBL_W'(1);
                        if (n_lbl == '0) begin
                            fin_len = {lacc_eff[7:0], i_byte};
                            fin_do  = 1'b1;
                        end
                    end
                end
                btw_pkg::PH_INT: begin
                    // The leading byte of a negative INTEGER fills the accumulator with ones.
                    if ((vbl_eff == lacc_eff) && (r_tag == btw_pkg::T_INTEGER) && i_byte[7]) begin
                        acc_base = '1;
                    end
                    n_vacc = {acc_base[23:0], i_byte};
                    n_vbl  = vbl_eff - 16'd1;
                    if (n_vbl == 16'd0) begin
                        rec0.kind = btw_pkg::KIND_VALUE;
                        rec0.vlen = lacc_eff;
                        rec0.voff = 16'(int_voff);
                        rec0.noff = 16'(pos_p1);
                        rec0.ival = n_vacc;
                        n_phase   = btw_pkg::PH_TAG;
                        num       = 2'd1;
                    end
                end
                btw_pkg::PH_SKIP: begin
                    n_vbl = vbl_eff - 16'd1;
                    if (n_vbl == 16'd0) begin
                        n_phase = btw_pkg::PH_TAG;
                    end
                end
                default: begin
                    n_phase = btw_pkg::PH_IDLE;
                end
            endcase
            n_pos = btw_pkg::POS_W'(pos_p1);
        end

        // Header completion: length rules, offset range and the next phase.
        lim = (i_int_max_len > btw_pkg::INT_LEN_CAP) ? btw_pkg::INT_LEN_CAP : i_int_max_len;
        if (btw_pkg::is_constructed(r_tag) || (r_tag == btw_pkg::T_NULL)) begin
            next_off = btw_pkg::NEXT_W'(pos_p1);
        end else begin
            next_off = btw_pkg::NEXT_W'(pos_p1) + btw_pkg::NEXT_W'(fin_len);
        end
        len_bad = ((r_tag == btw_pkg::T_NULL) && (fin_len != 16'd0)) ||
                  ((r_tag == btw_pkg::T_IPADDR) && (fin_len != 16'd4)) ||
                  (btw_pkg::is_int_class(r_tag) && (fin_len > 16'(lim)));
        ovf = pos_p1[btw_pkg::POS_W] ||
              (next_off > btw_pkg::NEXT_W'(btw_pkg::OFFSET_MASK));

        if (fin_do) begin
            rec0.vlen = fin_len;
            num       = 2'd1;
            if (ovf) begin
                rec0.status = btw_pkg::ST_BAD_FORM;
                n_phase     = btw_pkg::PH_ERROR;
            end else if (len_bad) begin
                rec0.status = btw_pkg::ST_BAD_LEN;
                rec0.voff   = 16'(pos_p1);
                n_phase     = btw_pkg::PH_ERROR;
            end else begin
                rec0.voff = 16'(pos_p1);
                rec0.noff = 16'(next_off);
                n_vbl     = fin_len;
                n_vacc    = '0;
                if (btw_pkg::is_constructed(r_tag) || (r_tag == btw_pkg::T_NULL)) begin
                    n_phase = btw_pkg::PH_TAG;
                end else if (btw_pkg::is_int_class(r_tag)) begin
                    if (fin_len == 16'd0) begin
                        // An empty integer gets its value record on the same byte.
                        rec1.kind = btw_pkg::KIND_VALUE;
                        rec1.voff = 16'(pos_p1);
                        rec1.noff = 16'(next_off);
                        n_phase   = btw_pkg::PH_TAG;
                        num       = 2'd2;
                    end else begin
                        n_phase = btw_pkg::PH_INT;
                    end
                end else begin
                    n_phase = (fin_len == 16'd0) ? btw_pkg::PH_TAG : btw_pkg::PH_SKIP;
                end
            end
        end

        rec0.tag  = n_tag;
        rec0.hoff = 16'(n_hoff);
        rec1.tag  = n_tag;
        rec1.hoff = 16'(n_hoff);
        rec0.last = (num == 2'd1);
        rec1.last = (num == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= btw_pkg::PH_IDLE;
            r_pos   <= '0;
            r_hoff  <= '0;
            r_tag   <= '0;
            r_lacc  <= '0;
            r_lbl   <= '0;
            r_vbl   <= '0;
            r_vacc  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_hoff  <= n_hoff;
            r_tag   <= n_tag;
            r_lacc  <= n_lacc;
            r_lbl   <= n_lbl;
            r_vbl   <= n_vbl;
            r_vacc  <= n_vacc;
        end
    end

    assign o_rec0 = rec0;
    assign o_rec1 = rec1;
    assign o_num  = i_en ? num : 2'd0;

endmodule

### design/btw_fifo.sv
// Result queue: takes up to two records a cycle, hands out one.
// Depends on btw_pkg for the record type and the queue depth.
module btw_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [1:0]                     i_push_num,
    input  btw_pkg::t_rec                  i_rec0,
    input  btw_pkg::t_rec                  i_rec1,
    input  logic                           i_pop,
    output logic                           o_valid,
    output btw_pkg::t_rec                  o_rec,
    output logic [btw_pkg::FIFO_CNT_W-1:0] o_count
);

    btw_pkg::t_rec                   r_mem [btw_pkg::FIFO_DEPTH];
    logic [btw_pkg::FIFO_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [btw_pkg::FIFO_CNT_W-1:0]  r_count, n_count;
    logic                            pop;

    assign pop = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count + btw_pkg::FIFO_CNT_W'(i_push_num) -
                  btw_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_rec0;
        end
        if (i_push_num == 2'd2) begin
            r_mem[r_wr_ptr + btw_pkg::FIFO_PTR_W'(1)] <= i_rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + btw_pkg::FIFO_PTR_W'(i_push_num);
            r_rd_ptr <= r_rd_ptr + btw_pkg::FIFO_PTR_W'(pop);
            r_count  <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### design/ber_tlv_stream_walker_unit.sv
// Top level of the BER TLV stream walker: input register, parser, result queue.
// Depends on btw_pkg, btw_parser and btw_fifo.
// A byte accepted on the slave side waits in the input register until the parser takes
// it; its records are written into the result queue and show on the master side from there.
// Throughput: one byte per cycle; the byte is parsed only while the four-entry result
// queue holds at most two records, so output back-pressure stalls the input side.
// Reset (synchronous, active low): parser idle until a message start, queue empty,
// int_max_len back to 4.
module ber_tlv_stream_walker_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration: int_max_len.
    input  logic          i_cfg_wr_en,
    input  logic [2:0]    i_cfg_wr_data,
    // Slave side.
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic          s_axis_tuser,   // [0] first
    // Master side.
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // [7:0] tag_byte, [23:8] value_length,
                                          // [39:24] header_offset, [55:40] value_offset,
                                          // [71:56] next_offset, [73:72] status,
                                          // [105:74] int_value, [111:106] zero
    output logic          m_axis_tuser,   // [0] record_kind
    output logic          m_axis_tlast    // last_of_run
);

    logic                           r_in_valid;
    logic [7:0]                     r_in_byte;
    logic                           r_in_first;
    logic [2:0]                     r_int_max_len;

    logic                           fire;
    logic                           room;
    btw_pkg::t_rec                  rec0, rec1, out_rec;
    logic [1:0]                     push_num;
    logic [btw_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic                           out_valid;

    // The queue must be able to absorb the two records one byte can cause. The check
    // uses the registered count only, so master-side ready never reaches slave-side ready.
    assign room = (fifo_count <= btw_pkg::FIFO_CNT_W'(btw_pkg::FIFO_DEPTH - 2));
    assign fire = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || fire;

    // The configuration register must be written only while the block is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_max_len <= btw_pkg::INT_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_int_max_len <= i_cfg_wr_data;
        end
    end

    // Input register: holds one byte transaction until the parser takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
        end
    end

    btw_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (fire),
        .i_byte        (r_in_byte),
        .i_first       (r_in_first),
        .i_int_max_len (r_int_max_len),
        .o_rec0        (rec0),
        .o_rec1        (rec1),
        .o_num         (push_num)
    );

    btw_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_num (push_num),
        .i_rec0     (rec0),
        .i_rec1     (rec1),
        .i_pop      (m_axis_tready),
        .o_valid    (out_valid),
        .o_rec      (out_rec),
        .o_count    (fifo_count)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {6'd0, out_rec.ival, out_rec.status, out_rec.noff,
                            out_rec.voff, out_rec.hoff, out_rec.vlen, out_rec.tag};
    assign m_axis_tuser  = out_rec.kind;
    assign m_axis_tlast  = out_rec.last;

    // The queue never holds more records than it has entries.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= btw_pkg::FIFO_CNT_W'(btw_pkg::FIFO_DEPTH))
        else $error("result queue over its depth");

    // Records enter the queue only when a byte is parsed.
    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> fifo_count <= $past(fifo_count))
        else $error("result queue grew without a parsed byte");

    // A byte causing two records gives a header and then a value, the value last.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_num == 2'd2 |-> (rec0.kind == btw_pkg::KIND_HEADER) &&
                             (rec1.kind == btw_pkg::KIND_VALUE) && !rec0.last && rec1.last)
        else $error("bad record pair from one byte");

endmodule
